// File: rtl/lbc_pkg.sv
// Shared types and codes for the LRU block buffer cache.
package lbc_pkg;

  localparam int unsigned SLOT_W = 8;  // wide enough for the largest cache

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_DONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BUFFER = 2'd1,
    ST_MISUSE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [3:0]        dev;
    logic [31:0]       blk;
    logic [7:0]        cnt;
    logic              valid;
    logic              dirty;
  } entry_t;

  typedef struct packed {
    logic load_front;
    logic shift;
    logic inc;
    logic retag;
    logic set_dirty;
    logic dec;
    logic done;
  } cell_cmd_t;

endpackage

// File: rtl/lbc_cell.sv
// One recency position of the buffer cache: holds the entry that sits there.
module lbc_cell #(
  parameter int unsigned RESET_SLOT = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lbc_pkg::cell_cmd_t cmd_i,
  input  lbc_pkg::entry_t    left_i,
  input  lbc_pkg::entry_t    front_i,
  input  logic [3:0]         dev_i,
  input  logic [31:0]        blk_i,
  output lbc_pkg::entry_t    entry_o,
  output logic               hit_o,
  output logic               vic_o
);
  import lbc_pkg::*;

  localparam entry_t RESET_ENTRY = '{slot: SLOT_W'(RESET_SLOT), default: '0};

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    priority if (cmd_i.load_front) begin
      entry_d = front_i;
    end else if (cmd_i.shift) begin
      entry_d = left_i;
    end else begin
      if (cmd_i.inc && entry_q.cnt != 8'hFF) entry_d.cnt = entry_q.cnt + 8'd1;
      if (cmd_i.retag) begin
        entry_d.dev   = dev_i;
        entry_d.blk   = blk_i;
        entry_d.valid = 1'b0;
        entry_d.dirty = 1'b0;
        entry_d.cnt   = 8'd1;
      end
      if (cmd_i.set_dirty) entry_d.dirty = 1'b1;
      if (cmd_i.dec) entry_d.cnt = entry_q.cnt - 8'd1;
      if (cmd_i.done) begin
        entry_d.valid = 1'b1;
        entry_d.dirty = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= RESET_ENTRY;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = (entry_q.dev == dev_i) && (entry_q.blk == blk_i);
  assign vic_o   = (entry_q.cnt == 8'd0) && !entry_q.dirty;

endmodule

// File: rtl/lru_block_buffer_cache_unit.sv
// LRU block buffer cache: tag lookup, victim choice and reference counting.
//
// Input channel s_axis: one request item per handshake. tuser carries the
// request kind (get, mark written, release, disk done); tdata carries the
// device, block number and slot. Output channel m_axis: exactly one result
// item per request (slot, hit flag, read flag, status).
// Buffers sit in a chain of cells ordered by recency, cell 0 most recent.
// A get walks the hit flags from cell 0 upward, one cell a cycle, then the
// victim flags from the last cell down; write, release and disk done go
// straight to a single execute state. The scan counter steps over the chain.
// A release of the last reference shifts the cells ahead of the buffer one
// place back and loads it into cell 0.
// Requests are taken one at a time; the next is accepted while a result
// still waits in the output register. If the receiver stalls, a finished
// request holds its place until the output register frees up.
// Reset clears all tags, counts and marks and orders the slots from the
// highest at cell 0 down to slot 0 at the last cell; no clearing pass.
module lru_block_buffer_cache_unit #(
  parameter int unsigned BUFFER_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // req_type
  input  logic [47:0] s_axis_tdata_i,   // device_id, block_number, slot_index, zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // buffer_slot, was_hit, needs_read, status, zero pad
);
  import lbc_pkg::*;

  localparam int unsigned PW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam logic [PW-1:0] LAST = PW'(BUFFER_COUNT - 1);
  localparam logic [8:0] NCNT = 9'(BUFFER_COUNT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HSCAN = 4'b0010,
    S_VSCAN = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [PW-1:0] p_q, p_d;
  req_e req_q;
  logic [3:0] dev_q;
  logic [31:0] blk_q;
  logic [4:0] slot_q;

  logic out_valid_q, out_valid_d;
  logic [15:0] out_data_q, out_data_d;

  entry_t    ent [BUFFER_COUNT];
  cell_cmd_t cmd [BUFFER_COUNT];
  logic [BUFFER_COUNT-1:0] hit_vec, vic_vec, smatch, suffix;
  logic [$bits(entry_t)-1:0] sel_bits;
  entry_t sel_entry, front_entry, scan_entry;
  logic out_free, in_range;

  for (genvar k = 0; k < BUFFER_COUNT; k++) begin : g_cell
    lbc_cell #(.RESET_SLOT(BUFFER_COUNT - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[k]),
      .left_i  (ent[(k > 0) ? k - 1 : 0]),
      .front_i (front_entry),
      .dev_i   (dev_q),
      .blk_i   (blk_q),
      .entry_o (ent[k]),
      .hit_o   (hit_vec[k]),
      .vic_o   (vic_vec[k])
    );
    assign smatch[k] = (ent[k].slot == {3'b000, slot_q});
  end

  always_comb begin
    logic acc;
    acc      = 1'b0;
    sel_bits = '0;
    for (int k = BUFFER_COUNT - 1; k >= 0; k--) begin
      acc       = acc | smatch[k];
      suffix[k] = acc;
      sel_bits  = sel_bits | ({$bits(entry_t){smatch[k]}} & ent[k]);
    end
  end

  always_comb begin
    sel_entry       = entry_t'(sel_bits);
    front_entry     = sel_entry;
    front_entry.cnt = 8'd0;
  end

  assign scan_entry = ent[p_q];
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign in_range   = {4'b0000, slot_q} < NCNT;

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    for (int k = 0; k < BUFFER_COUNT; k++) cmd[k] = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          p_d     = '0;
          state_d = (req_e'(s_axis_tuser_i) == REQ_GET) ? S_HSCAN : S_EXEC;
        end
      end
      S_HSCAN: begin
        if (hit_vec[p_q]) begin
          if (out_free) begin
            cmd[p_q].inc = 1'b1;
            out_valid_d  = 1'b1;
            out_data_d   = {7'd0, ST_OK, !scan_entry.valid, 1'b1, scan_entry.slot[4:0]};
            state_d      = S_IDLE;
          end
        end else if (p_q == LAST) begin
          state_d = S_VSCAN;
        end else begin
          p_d = p_q + 1'b1;
        end
      end
      S_VSCAN: begin
        if (vic_vec[p_q]) begin
          if (out_free) begin
            cmd[p_q].retag = 1'b1;
            out_valid_d    = 1'b1;
            out_data_d     = {7'd0, ST_OK, 1'b1, 1'b0, scan_entry.slot[4:0]};
            state_d        = S_IDLE;
          end
        end else if (p_q == '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = {7'd0, ST_NO_BUFFER, 7'd0};
            state_d     = S_IDLE;
          end
        end else begin
          p_d = p_q - 1'b1;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          out_data_d  = {7'd0, ST_OK, 2'b00, slot_q};
          if (!in_range) begin
            out_data_d = {7'd0, ST_MISUSE, 2'b00, slot_q};
          end else if (req_q == REQ_DONE) begin
            for (int k = 0; k < BUFFER_COUNT; k++) cmd[k].done = smatch[k];
          end else if (sel_entry.cnt == 8'd0) begin
            out_data_d = {7'd0, ST_MISUSE, 2'b00, slot_q};
          end else if (req_q == REQ_WRITE) begin
            for (int k = 0; k < BUFFER_COUNT; k++) cmd[k].set_dirty = smatch[k];
          end else if (sel_entry.cnt == 8'd1) begin
            // last reference dropped: move the buffer to the front
            cmd[0].load_front = 1'b1;
            for (int k = 1; k < BUFFER_COUNT; k++) cmd[k].shift = suffix[k];
          end else begin
            for (int k = 0; k < BUFFER_COUNT; k++) cmd[k].dec = smatch[k];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (state_q == S_IDLE && s_axis_tvalid_i) begin
      req_q  <= req_e'(s_axis_tuser_i);
      dev_q  <= s_axis_tdata_i[3:0];
      blk_q  <= s_axis_tdata_i[35:4];
      slot_q <= s_axis_tdata_i[40:36];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: tb/lru_block_buffer_cache_unit_test.sv
// Testbench for the LRU block buffer cache: random and directed requests checked against a model.
`timescale 1ns / 100ps

module lru_block_buffer_cache_unit_test;
  import lbc_pkg::*;

  localparam int unsigned NBUF = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  dev;
    logic [31:0] blk;
    logic [4:0]  slot;
  } request_t;

  // Lowest bit up: slot, hit, rd, st
  typedef struct packed {
    logic [1:0] st;
    logic       rd;
    logic       hit;
    logic [4:0] slot;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [1:0]  s_axis_tuser_i = '0;
  logic [47:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  // Acceptance seen at the last rising edge
  logic s_axis_tready_o_q = 1'b0;

  lru_block_buffer_cache_unit #(.BUFFER_COUNT(NBUF)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tuser_i,
    .s_axis_tdata_i, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  // Cache shadow state
  logic [3:0]  dev_tag [NBUF];
  logic [31:0] blk_tag [NBUF];
  logic [7:0]  ref_cnt [NBUF];
  logic        valid_m [NBUF];
  logic        dirty_m [NBUF];
  logic [4:0]  order   [NBUF];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       errors = 0;
  int       cycles = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       stim_done = 0;

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int s, p, k;
    a = '0;
    if (r.kind == REQ_GET) begin
      for (p = 0; p < NBUF; p++) begin
        s = order[p];
        if (dev_tag[s] == r.dev && blk_tag[s] == r.blk) begin
          if (ref_cnt[s] != 8'hff) ref_cnt[s]++;
          a.slot = 5'(s); a.hit = 1'b1; a.rd = !valid_m[s]; a.st = ST_OK;
          return a;
        end
      end
      for (p = NBUF - 1; p >= 0; p--) begin
        s = order[p];
        if (ref_cnt[s] == 8'd0 && !dirty_m[s]) begin
          dev_tag[s] = r.dev; blk_tag[s] = r.blk;
          valid_m[s] = 1'b0; dirty_m[s] = 1'b0; ref_cnt[s] = 8'd1;
          a.slot = 5'(s); a.rd = 1'b1; a.st = ST_OK;
          return a;
        end
      end
      a.st = ST_NO_BUFFER;
      return a;
    end
    a.slot = r.slot;
    if (r.kind == REQ_DONE) begin
      valid_m[r.slot] = 1'b1; dirty_m[r.slot] = 1'b0; a.st = ST_OK;
      return a;
    end
    if (ref_cnt[r.slot] == 8'd0) begin
      a.st = ST_MISUSE;
      return a;
    end
    a.st = ST_OK;
    if (r.kind == REQ_WRITE) begin
      dirty_m[r.slot] = 1'b1;
    end else begin
      ref_cnt[r.slot]--;
      if (ref_cnt[r.slot] == 8'd0) begin
        for (p = 0; p < NBUF; p++) if (order[p] == r.slot) break;
        for (k = p; k > 0; k--) order[k] = order[k-1];
        order[0] = r.slot;
      end
    end
    return a;
  endfunction

  // Driver: hold the item until accepted, then load the next at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || s_axis_tready_o_q) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          request_t r;
          r = pending_reqs.pop_front();
          s_axis_tuser_i  <= r.kind;
          s_axis_tdata_i  <= {7'd0, r.slot, r.blk, r.dev};
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    s_axis_tready_o_q <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        request_t r;
        r = '{kind: s_axis_tuser_i, dev: s_axis_tdata_i[3:0], blk: s_axis_tdata_i[35:4],
              slot: s_axis_tdata_i[40:36]};
        expected_answers.push_back(predict_answer(r));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        answer_t got;
        got = m_axis_tdata_o[8:0];
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors <= errors + 1;
        end else begin
          answer_t exp_a;
          exp_a = expected_answers.pop_front();
          if (got !== exp_a) begin
            $display("%0t: mismatch slot/hit/rd/st expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                     $time, exp_a.slot, exp_a.hit, exp_a.rd, exp_a.st,
                     got.slot, got.hit, got.rd, got.st);
            errors <= errors + 1;
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic request_t mk(logic [1:0] k, logic [3:0] d, logic [31:0] b, logic [4:0] s);
    request_t r;
    r.kind = k; r.dev = d; r.blk = b; r.slot = s;
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_answers.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int ph, n, i;
    logic [3:0] d;
    logic [31:0] b;
    for (i = 0; i < NBUF; i++) begin
      dev_tag[i] = '0; blk_tag[i] = '0; ref_cnt[i] = '0;
      valid_m[i] = 1'b0; dirty_m[i] = 1'b0; order[i] = 5'(NBUF - 1 - i);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: hit on reset tags, misuse, extremes, saturation, exhaustion
    pending_reqs.push_back(mk(REQ_GET, 4'd0, 32'd0, 5'd0));
    pending_reqs.push_back(mk(REQ_WRITE, 4'd0, 32'd0, 5'd5));
    pending_reqs.push_back(mk(REQ_RELEASE, 4'd0, 32'd0, 5'd5));
    pending_reqs.push_back(mk(REQ_GET, 4'hf, 32'hffff_ffff, 5'd31));
    pending_reqs.push_back(mk(REQ_DONE, 4'd0, 32'd0, 5'd31));
    pending_reqs.push_back(mk(REQ_DONE, 4'd0, 32'd0, 5'd0));
    pending_reqs.push_back(mk(REQ_GET, 4'hf, 32'hffff_ffff, 5'd0));
    pending_reqs.push_back(mk(REQ_WRITE, 4'hf, 32'h0, 5'd31));
    pending_reqs.push_back(mk(REQ_RELEASE, 4'h0, 32'h0, 5'd31));
    pending_reqs.push_back(mk(REQ_RELEASE, 4'h0, 32'h0, 5'd31));
    pending_reqs.push_back(mk(REQ_RELEASE, 4'h0, 32'h0, 5'd0));
    for (i = 0; i < 34; i++) pending_reqs.push_back(mk(REQ_GET, 4'd3, 32'(i), 5'd0));
    for (i = 0; i < 260; i++) pending_reqs.push_back(mk(REQ_GET, 4'd3, 32'd1, 5'd0));
    wait_drained();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (n = 0; n < 260; n++) begin
        // Narrow tag pool for hits; occasional wide values for bit coverage
        d = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(2));
        b = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(40));
        case ($urandom_range(9))
          0, 1, 2, 3: pending_reqs.push_back(mk(REQ_GET, d, b, 5'($urandom)));
          4:          pending_reqs.push_back(mk(REQ_WRITE, d, b, 5'($urandom)));
          5, 6, 7:    pending_reqs.push_back(mk(REQ_RELEASE, d, b, 5'($urandom)));
          default:    pending_reqs.push_back(mk(REQ_DONE, d, b, 5'($urandom)));
        endcase
      end
      wait_drained();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (80) @(posedge clk_i);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
